// ===== rtl/lrhs_pkg.sv =====
// Package for the LCG range/Hamming statistics block.
// Shared types, register indexes, sequencer states and bit-count helpers.
// No dependencies.
`timescale 1ns / 1ps

package lrhs_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ModBitsW = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DistW    = 6;

  localparam logic [WordW-1:0] IterReset  = 32'd256;
  localparam logic [WordW-1:0] RangeLoRst = 32'h0000_0000;
  localparam logic [WordW-1:0] RangeHiRst = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] RefPatRst  = 32'h0000_0000;

  localparam logic [WordW-1:0] PopMask1 = 32'h5555_5555;
  localparam logic [WordW-1:0] PopMask2 = 32'h3333_3333;
  localparam logic [WordW-1:0] PopMask4 = 32'h0F0F_0F0F;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ITERATIONS  = 3'd0,
    CFG_RANGE_LOW   = 3'd1,
    CFG_RANGE_HIGH  = 3'd2,
    CFG_REF_PATTERN = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MUL   = 3'd1,
    ST_ADD   = 3'd2,
    ST_FLUSH = 3'd3,
    ST_EMIT  = 3'd4
  } state_e;

  // Per-cycle commands from the sequencer to the datapath units
  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic stat;
    logic emit;
  } ctrl_t;

  // SWAR bit count; byte lanes are summed directly instead of multiplied
  function automatic logic [DistW-1:0] popcount32(input logic [WordW-1:0] v);
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
    v1 = v - ((v >> 1) & PopMask1);
    v2 = (v1 & PopMask2) + ((v1 >> 2) & PopMask2);
    v3 = (v2 + (v2 >> 4)) & PopMask4;
    return v3[5:0] + v3[13:8] + v3[21:16] + v3[29:24];
  endfunction

  function automatic logic [WordW-1:0] mask_from_bits(input logic [ModBitsW-1:0] bits);
    if (bits >= 6'd32) begin
      return '1;
    end else begin
      return (32'h1 << bits) - 32'h1;
    end
  endfunction

endpackage

// ===== rtl/lrhs_ctrl.sv =====
// Sequencer for the LCG job engine: job load, multiply/add step phases, flush, emit.
// Owns the step counter. Depends on lrhs_pkg.
`timescale 1ns / 1ps

module lrhs_ctrl import lrhs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [WordW-1:0] iterations_i,
  input  logic             out_free_i,
  output logic             in_stall_o,
  output ctrl_t            ctrl_o
);

  state_e           state_q, state_d;
  logic [WordW-1:0] steps_q, steps_d;
  logic [WordW-1:0] steps_inc;

  assign steps_inc = steps_q + 32'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (iterations_i == '0) ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = (steps_inc == iterations_i) ? ST_FLUSH : ST_MUL;
      end
      ST_FLUSH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = (state_q != ST_IDLE);
    steps_d    = steps_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.load = in_valid_i;
        if (in_valid_i) begin
          steps_d = '0;
        end
      end
      ST_MUL: begin
        ctrl_o.mul  = 1'b1;
        // statistics of the value produced by the previous step
        ctrl_o.stat = (steps_q != '0);
      end
      ST_ADD: begin
        ctrl_o.add = 1'b1;
        steps_d    = steps_inc;
      end
      ST_FLUSH: begin
        ctrl_o.stat = 1'b1;
      end
      ST_EMIT: begin
        ctrl_o.emit = out_free_i;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
    end
  end

endmodule

// ===== rtl/lrhs_step_unit.sv =====
// Shared generator unit: one 32x32 multiply, then add and modulus mask.
// Holds the job's multiplier, increment, mask and current value. Depends on lrhs_pkg.
`timescale 1ns / 1ps

module lrhs_step_unit import lrhs_pkg::*; (
  input  logic                clk_i,
  input  ctrl_t               ctrl_i,
  input  logic [WordW-1:0]    multiplier_i,
  input  logic [WordW-1:0]    increment_i,
  input  logic [ModBitsW-1:0] modulus_bits_i,
  input  logic [WordW-1:0]    seed_i,
  output logic [WordW-1:0]    value_o
);

  logic [WordW-1:0] mult_q, incr_q, mask_q;
  logic [WordW-1:0] x_q, x_d;
  logic [WordW-1:0] prod_q, prod_d;

  assign prod_d = mult_q * x_q;
  assign x_d    = (prod_q + incr_q) & mask_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mult_q <= multiplier_i;
      incr_q <= increment_i;
      mask_q <= mask_from_bits(modulus_bits_i);
      x_q    <= seed_i;  // seed is not reduced
    end else if (ctrl_i.add) begin
      x_q <= x_d;
    end
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  assign value_o = x_q;

endmodule

// ===== rtl/lrhs_stats.sv =====
// Statistics unit: in-range counter and min/max Hamming distance to the reference word.
// Updated once per generator step. Depends on lrhs_pkg.
`timescale 1ns / 1ps

module lrhs_stats import lrhs_pkg::*; (
  input  logic             clk_i,
  input  ctrl_t            ctrl_i,
  input  logic [WordW-1:0] value_i,
  input  logic [WordW-1:0] range_low_i,
  input  logic [WordW-1:0] range_high_i,
  input  logic [WordW-1:0] ref_pattern_i,
  input  logic [WordW-1:0] count_start_i,
  input  logic [WordW-1:0] min_start_i,
  input  logic [WordW-1:0] max_start_i,
  output logic [WordW-1:0] count_o,
  output logic [WordW-1:0] min_o,
  output logic [WordW-1:0] max_o
);

  logic [WordW-1:0] count_q, min_q, max_q;
  logic [WordW-1:0] ham_dist;
  logic             in_range;

  assign ham_dist = WordW'(popcount32(value_i ^ ref_pattern_i));
  assign in_range = (range_low_i <= value_i) && (value_i <= range_high_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      count_q <= count_start_i;
      min_q   <= min_start_i;
      max_q   <= max_start_i;
    end else if (ctrl_i.stat) begin
      if (in_range) begin
        count_q <= count_q + 32'd1;
      end
      if (ham_dist < min_q) begin
        min_q <= ham_dist;
      end
      if (ham_dist > max_q) begin
        max_q <= ham_dist;
      end
    end
  end

  assign count_o = count_q;
  assign min_o   = min_q;
  assign max_o   = max_q;

endmodule

// ===== rtl/lcg_range_hamming_stats.sv =====
// Top level of the LCG range/Hamming statistics job engine.
// Uses lrhs_pkg, lrhs_ctrl, lrhs_step_unit and lrhs_stats.
`timescale 1ns / 1ps

// Each input transaction is one generator job; one result transaction follows per job.
// With N >= 1 iterations every generator step uses the single 32x32 multiplier in the
// multiply state and the add/mask stage in the following add state, the statistics of a
// step are taken while the following multiply runs, and a flush state takes the
// statistics of the last step before the emit state loads the result into the output
// register. With zero iterations the job goes from acceptance straight to the emit
// state. The input is stalled for the whole job and is free again the cycle after the
// result is loaded, so a new job is only taken once the previous one is through. The
// next job is taken even if the consumer has not collected the previous result yet; a
// result that cannot be loaded because the output register is still held by a stall
// keeps the engine waiting.
// Configuration writes are always ready and should only be issued while no job is in
// flight.

module lcg_range_hamming_stats import lrhs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [WordW-1:0]    cfg_data_i,
  // job input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [WordW-1:0]    multiplier_i,
  input  logic [WordW-1:0]    increment_i,
  input  logic [ModBitsW-1:0] modulus_bits_i,
  input  logic [WordW-1:0]    seed_i,
  input  logic [WordW-1:0]    count_start_i,
  input  logic [WordW-1:0]    min_start_i,
  input  logic [WordW-1:0]    max_start_i,
  input  logic                last_job_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordW-1:0]    final_value_o,
  output logic [WordW-1:0]    final_count_o,
  output logic [WordW-1:0]    lowest_distance_o,
  output logic [WordW-1:0]    highest_distance_o,
  output logic                last_job_out_o
);

  logic [WordW-1:0] iterations_q, range_low_q, range_high_q, ref_pattern_q;
  logic             last_q;
  logic             out_valid_q;
  logic             out_free;
  ctrl_t            ctrl;
  logic [WordW-1:0] value, count, dmin, dmax;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iterations_q  <= IterReset;
      range_low_q   <= RangeLoRst;
      range_high_q  <= RangeHiRst;
      ref_pattern_q <= RefPatRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ITERATIONS:  iterations_q  <= cfg_data_i;
        CFG_RANGE_LOW:   range_low_q   <= cfg_data_i;
        CFG_RANGE_HIGH:  range_high_q  <= cfg_data_i;
        CFG_REF_PATTERN: ref_pattern_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  lrhs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .iterations_i (iterations_q),
    .out_free_i   (out_free),
    .in_stall_o   (in_stall_o),
    .ctrl_o       (ctrl)
  );

  lrhs_step_unit u_step (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .multiplier_i   (multiplier_i),
    .increment_i    (increment_i),
    .modulus_bits_i (modulus_bits_i),
    .seed_i         (seed_i),
    .value_o        (value)
  );

  lrhs_stats u_stats (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .value_i       (value),
    .range_low_i   (range_low_q),
    .range_high_i  (range_high_q),
    .ref_pattern_i (ref_pattern_q),
    .count_start_i (count_start_i),
    .min_start_i   (min_start_i),
    .max_start_i   (max_start_i),
    .count_o       (count),
    .min_o         (dmin),
    .max_o         (dmax)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      last_q <= last_job_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      final_value_o      <= value;
      final_count_o      <= count;
      lowest_distance_o  <= dmin;
      highest_distance_o <= dmax;
      last_job_out_o     <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/lrhs_checker.sv =====
// Port-level checker for lcg_range_hamming_stats, attached by bind.
// Depends on lrhs_pkg.
`timescale 1ns / 1ps

module lrhs_checker import lrhs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WordW-1:0] final_value_o,
  input logic [WordW-1:0] final_count_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(final_value_o)
      && $stable(final_count_o))
    else $error("stalled result changed");

  // after a job is accepted the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again while job in flight");

  // no result can appear the cycle right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early after acceptance");

  // a new result means the job finished and the input is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result presented while still busy");

endmodule

bind lcg_range_hamming_stats lrhs_checker u_lrhs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .final_value_o (final_value_o),
  .final_count_o (final_count_o)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for lcg_range_hamming_stats: generator jobs against an in-bench model.
// Depends on lrhs_pkg (widths, register indexes) and the lcg_range_hamming_stats RTL.
`timescale 1ns / 1ps

module tb_top;
  import lrhs_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned RandPhases = 17;
  localparam int unsigned PhaseJobs  = 100;

  typedef struct {
    logic [WordW-1:0]    mult;
    logic [WordW-1:0]    incr;
    logic [ModBitsW-1:0] bits;
    logic [WordW-1:0]    seed;
    logic [WordW-1:0]    count0;
    logic [WordW-1:0]    min0;
    logic [WordW-1:0]    max0;
    logic                last;
  } job_t;

  typedef struct {
    logic [WordW-1:0] value;
    logic [WordW-1:0] count;
    logic [WordW-1:0] lo_dist;
    logic [WordW-1:0] hi_dist;
    logic             last;
  } stats_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [WordW-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [WordW-1:0]    multiplier_i = '0;
  logic [WordW-1:0]    increment_i = '0;
  logic [ModBitsW-1:0] modulus_bits_i = '0;
  logic [WordW-1:0]    seed_i = '0;
  logic [WordW-1:0]    count_start_i = '0;
  logic [WordW-1:0]    min_start_i = '0;
  logic [WordW-1:0]    max_start_i = '0;
  logic                last_job_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WordW-1:0]    final_value_o;
  logic [WordW-1:0]    final_count_o;
  logic [WordW-1:0]    lowest_distance_o;
  logic [WordW-1:0]    highest_distance_o;
  logic                last_job_out_o;

  // model copy of the configuration registers
  logic [WordW-1:0] iter_cfg   = IterReset;
  logic [WordW-1:0] range_lo   = RangeLoRst;
  logic [WordW-1:0] range_hi   = RangeHiRst;
  logic [WordW-1:0] ref_word   = RefPatRst;

  stats_t      expected_stats[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b0;
  int unsigned stall_run = 0;
  int unsigned free_run = 0;

  lcg_range_hamming_stats dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .multiplier_i       (multiplier_i),
    .increment_i        (increment_i),
    .modulus_bits_i     (modulus_bits_i),
    .seed_i             (seed_i),
    .count_start_i      (count_start_i),
    .min_start_i        (min_start_i),
    .max_start_i        (max_start_i),
    .last_job_i         (last_job_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .final_value_o      (final_value_o),
    .final_count_o      (final_count_o),
    .lowest_distance_o  (lowest_distance_o),
    .highest_distance_o (highest_distance_o),
    .last_job_out_o     (last_job_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic stats_t run_generator(job_t j);
    stats_t           s;
    logic [WordW-1:0] mask;
    logic [WordW-1:0] ham_dist;
    int unsigned      k;
    mask = (j.bits >= 6'd32) ? '1 : ((32'h1 << j.bits) - 32'h1);
    s.value   = j.seed;
    s.count   = j.count0;
    s.lo_dist = j.min0;
    s.hi_dist = j.max0;
    s.last    = j.last;
    for (k = 0; k < iter_cfg; k++) begin
      s.value = (j.mult * s.value + j.incr) & mask;
      if (s.value >= range_lo && s.value <= range_hi) s.count = s.count + 32'd1;
      ham_dist = WordW'($countones(s.value ^ ref_word));
      if (ham_dist < s.lo_dist) s.lo_dist = ham_dist;
      if (ham_dist > s.hi_dist) s.hi_dist = ham_dist;
    end
    return s;
  endfunction

  function automatic void compare_field(string name, logic [WordW-1:0] want,
                                        logic [WordW-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Result side: random stall and in-order comparison against the model.
  always @(posedge clk_i) begin : result_monitor
    stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stats.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, actual value %h count %h",
                 $time, final_value_o, final_count_o);
      end else begin
        want = expected_stats.pop_front();
        compare_field("final_value", want.value, final_value_o);
        compare_field("final_count", want.count, final_count_o);
        compare_field("lowest_distance", want.lo_dist, lowest_distance_o);
        compare_field("highest_distance", want.hi_dist, highest_distance_o);
        compare_field("last_job_out", {31'd0, want.last}, {31'd0, last_job_out_o});
      end
    end
    if (!rx_idle_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (free_run > 0) begin
      out_stall_i <= 1'b0;
      free_run--;
    end else begin
      out_stall_i <= 1'b0;
      stall_run = idle_len();
      free_run  = $urandom_range(0, 12);
    end
  end

  // Valid is left high after the transaction; it drops only ahead of a gap or when settle() stops sending.
  task automatic send_job(input job_t j);
    int unsigned gap;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    multiplier_i   <= j.mult;
    increment_i    <= j.incr;
    modulus_bits_i <= j.bits;
    seed_i         <= j.seed;
    count_start_i  <= j.count0;
    min_start_i    <= j.min0;
    max_start_i    <= j.max0;
    last_job_i     <= j.last;
    do @(posedge clk_i); while (in_stall_o);
    expected_stats.push_back(run_generator(j));
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_stats.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [WordW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ITERATIONS:  iter_cfg = val;
      CFG_RANGE_LOW:   range_lo = val;
      CFG_RANGE_HIGH:  range_hi = val;
      CFG_REF_PATTERN: ref_word = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic job_t make_job(logic [WordW-1:0] mult, logic [WordW-1:0] incr,
                                    logic [ModBitsW-1:0] bits, logic [WordW-1:0] seed,
                                    logic [WordW-1:0] count0, logic [WordW-1:0] min0,
                                    logic [WordW-1:0] max0, logic last);
    job_t j;
    j.mult = mult; j.incr = incr; j.bits = bits; j.seed = seed;
    j.count0 = count0; j.min0 = min0; j.max0 = max0; j.last = last;
    return j;
  endfunction

  // Reset configuration: 256 steps, full range, zero pattern; count wraps on the second job.
  task automatic test_reset_defaults();
    send_job(make_job('0, '0, '0, '0, '0, '0, '0, 1'b0));
    send_job(make_job('1, '1, '1, '1, '1, '1, '1, 1'b1));
  endtask

  task automatic test_zero_iterations();
    settle();
    write_reg(CFG_ITERATIONS, 32'd0);
    // seed comes back unreduced even with a zero-width modulus
    send_job(make_job($urandom, $urandom, 6'd0, $urandom, $urandom, 32'd7, 32'd3, 1'b0));
    send_job(make_job($urandom, $urandom, 6'd5, '1, 32'd12, '1, '0, 1'b1));
  endtask

  task automatic test_modulus_widths();
    logic [ModBitsW-1:0] widths [8];
    int unsigned         i;
    widths = '{6'd0, 6'd1, 6'd2, 6'd16, 6'd31, 6'd32, 6'd33, 6'd63};
    settle();
    write_reg(CFG_ITERATIONS, 32'd9);
    for (i = 0; i < 8; i++) begin
      send_job(make_job($urandom | 32'h1, $urandom | 32'h1, widths[i], $urandom, $urandom,
                        32'd32, 32'd0, i[0]));
    end
  endtask

  task automatic test_range_bounds();
    settle();
    // largest step count is written but never run
    write_reg(CFG_ITERATIONS, '1);
    write_reg(CFG_ITERATIONS, 32'd5);
    write_reg(CFG_RANGE_LOW, '1);
    write_reg(CFG_RANGE_HIGH, '1);
    send_job(make_job(32'd1, 32'd0, 6'd32, '1, 32'd0, '1, '0, 1'b0));
    send_job(make_job(32'd1, 32'd0, 6'd32, '0, 32'd0, '1, '0, 1'b1));
    settle();
    // inverted window: nothing is counted
    write_reg(CFG_RANGE_HIGH, '0);
    send_job(make_job(32'd1, 32'd1, 6'd32, '0, 32'd100, '1, '0, 1'b0));
    settle();
    write_reg(CFG_RANGE_LOW, '0);
    send_job(make_job(32'd0, 32'd0, 6'd32, $urandom, 32'd100, '1, '0, 1'b1));
  endtask

  task automatic test_reference_pattern();
    settle();
    write_reg(CFG_RANGE_HIGH, '1);
    write_reg(CFG_REF_PATTERN, '1);
    send_job(make_job(32'd0, 32'd0, 6'd32, 32'd5, 32'd0, 32'd40, 32'd0, 1'b0));
    send_job(make_job(32'd0, '1, 6'd32, 32'd5, 32'd0, 32'd40, 32'd0, 1'b1));
    settle();
    write_reg(CFG_REF_PATTERN, 32'h0F0F_0F0F);
    send_job(make_job($urandom, $urandom, 6'd32, $urandom, 32'd0, 32'd16, 32'd16, 1'b0));
  endtask

  task automatic test_random_phases();
    job_t             j;
    logic [WordW-1:0] lo;
    int unsigned      p;
    int unsigned      n;
    int unsigned      r;
    int unsigned      hold_at;
    for (p = 0; p < RandPhases; p++) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 8) write_reg(CFG_ITERATIONS, 32'd256);
      else if (r < 14) write_reg(CFG_ITERATIONS, $urandom_range(25, 120));
      else write_reg(CFG_ITERATIONS, $urandom_range(0, 24));
      case ($urandom_range(0, 4))
        0: begin
          write_reg(CFG_RANGE_LOW, '0);
          write_reg(CFG_RANGE_HIGH, '1);
        end
        1: begin
          lo = $urandom_range(0, 63);
          write_reg(CFG_RANGE_LOW, lo);
          write_reg(CFG_RANGE_HIGH, lo + $urandom_range(0, 200));
        end
        2: begin
          write_reg(CFG_RANGE_LOW, $urandom);
          write_reg(CFG_RANGE_HIGH, $urandom);
        end
        3: begin
          lo = $urandom;
          write_reg(CFG_RANGE_LOW, lo);
          write_reg(CFG_RANGE_HIGH, lo);
        end
        default: begin
          lo = $urandom_range(0, 32'h7FFF_FFFF);
          write_reg(CFG_RANGE_LOW, lo);
          write_reg(CFG_RANGE_HIGH, lo + 32'h4000_0000);
        end
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_REF_PATTERN, '0);
        1: write_reg(CFG_REF_PATTERN, '1);
        default: write_reg(CFG_REF_PATTERN, $urandom);
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      hold_at = $urandom_range(10, PhaseJobs - 10);
      for (n = 0; n < PhaseJobs; n++) begin
        if (n == hold_at && p % 4 == 0) settle();
        j.mult = ($urandom_range(0, 9) == 0) ? 32'd1 : $urandom;
        j.incr = $urandom;
        r = $urandom_range(0, 99);
        if (r < 45) j.bits = 6'd32;
        else if (r < 55) j.bits = ModBitsW'($urandom_range(33, 63));
        else j.bits = ModBitsW'($urandom_range(0, 31));
        j.seed   = $urandom;
        j.count0 = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                               : $urandom;
        j.min0   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 33);
        j.max0   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 33);
        j.last   = 1'($urandom_range(0, 1));
        send_job(j);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_zero_iterations();
    test_modulus_widths();
    test_range_bounds();
    test_reference_pattern();
    test_random_phases();
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
